/* rtl/core/mbwr_pkg.sv */
// package: frame constants, register kind codes, frame type and crc-16 helper
`default_nettype none

package mbwr_pkg;

	localparam int FrameLen = 8;
	localparam int DataLen  = 6;

	localparam logic [7:0]  FUNC_WRITE_SINGLE = 8'h06;
	localparam logic [15:0] CRC_INIT          = 16'hFFFF;
	localparam logic [15:0] CRC_POLY          = 16'hA001;
	localparam logic [15:0] REG_MAX           = 16'hFFFF;
	localparam logic [7:0]  SLAVE_RESET       = 8'h01;

	typedef logic [7:0] byte_t;

	typedef enum logic [1:0] {
		KIND_COIL     = 2'd0,
		KIND_DISCRETE = 2'd1,
		KIND_HOLDING  = 2'd2,
		KIND_INPUT    = 2'd3
	} reg_kind_t;

	// byte positions within the frame
	typedef enum logic [2:0] {
		POS_SLAVE  = 3'd0,
		POS_FUNC   = 3'd1,
		POS_ADDR_H = 3'd2,
		POS_ADDR_L = 3'd3,
		POS_VAL_H  = 3'd4,
		POS_VAL_L  = 3'd5,
		POS_CRC_L  = 3'd6,
		POS_CRC_H  = 3'd7
	} byte_pos_t;

	// frame body plus running crc
	typedef struct packed {
		logic [DataLen-1:0][7:0] data;
		logic [15:0]             crc;
	} frame_t;

	// reflected crc-16 update over one byte
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input byte_t b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

/* rtl/core/mbwr_serializer.sv */
// serializer: holds one finished frame and hands it out one word per cycle while out_stall is low
`default_nettype none

module mbwr_serializer (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            load_valid,
	input  wire mbwr_pkg::frame_t load_frame,
	output logic                 load_ready,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output logic [7:0]           frame_byte,
	output logic [2:0]           byte_index,
	output logic                 last_byte
);
	import mbwr_pkg::*;

	frame_t      frame_q;
	logic [2:0]  cnt_q;
	logic        valid_q;
	logic        take;
	logic        at_last;
	logic        load;

	assign take    = valid_q && !out_stall;
	assign at_last = (cnt_q == POS_CRC_H);

	// free when empty or when the last word leaves this cycle
	assign load_ready = !valid_q || (take && at_last);
	assign load       = load_valid && load_ready;

	// frame holding register and byte counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			cnt_q   <= 3'd0;
		end else if (load) begin
			valid_q <= 1'b1;
			cnt_q   <= 3'd0;
		end else if (take) begin
			if (at_last) begin
				valid_q <= 1'b0;
			end
			cnt_q <= cnt_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			frame_q <= load_frame;
		end
	end

	// byte select
	always_comb begin
		case (cnt_q)
			POS_SLAVE:  frame_byte = frame_q.data[0];
			POS_FUNC:   frame_byte = frame_q.data[1];
			POS_ADDR_H: frame_byte = frame_q.data[2];
			POS_ADDR_L: frame_byte = frame_q.data[3];
			POS_VAL_H:  frame_byte = frame_q.data[4];
			POS_VAL_L:  frame_byte = frame_q.data[5];
			POS_CRC_L:  frame_byte = frame_q.crc[7:0];
			default:    frame_byte = frame_q.crc[15:8];
		endcase
	end

	assign out_valid  = valid_q;
	assign byte_index = cnt_q;
	assign last_byte  = at_last;

endmodule

`default_nettype wire

/* rtl/core/modbus_write_register_frame.sv */
// top level: modbus rtu function 06 request builder with crc-16
//
// channel  | handshake          | payload
// ---------+--------------------+--------------------------------------
// in       | in_valid/in_stall  | reg_kind, reg_address, reg_value
// out      | out_valid/out_stall| frame_byte, byte_index, last_byte
// config   | cfg_we             | cfg_wdata (slave address)
//
// each request gives eight output words, one per cycle while out_stall is
// low; the byte-wide output serializer limits how often a request is taken.
// after accept a request passes value saturation (s1), crc over two bytes
// per stage (s2 to s4), then the serializer.
// reset clears all valid bits and sets the slave address to 1.
// a stall on the output holds the serializer and backs up the pipeline;
// nothing is lost or repeated.
`default_nettype none

module modbus_write_register_frame (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [7:0]  cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  reg_kind,
	input  wire logic [15:0] reg_address,
	input  wire logic signed [31:0] reg_value,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       frame_byte,
	output logic [2:0]       byte_index,
	output logic             last_byte
);
	import mbwr_pkg::*;

	logic [7:0]  slave_q;
	logic        valid_s1, valid_s2, valid_s3, valid_s4;
	frame_t      frame_s1, frame_s2, frame_s3, frame_s4;
	logic        en_s1, en_s2, en_s3, en_s4;
	logic        ser_ready;
	frame_t      frame_in;
	logic [15:0] reg_sat;
	logic        is_bit;

	// slave address register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_q <= SLAVE_RESET;
		end else if (cfg_we) begin
			slave_q <= cfg_wdata;
		end
	end

	// stage enables: a stage loads when empty or when it moves on
	assign en_s4    = !valid_s4 || ser_ready;
	assign en_s3    = !valid_s3 || en_s4;
	assign en_s2    = !valid_s2 || en_s3;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_stall = !en_s1;

	// value saturation and frame body assembly
	always_comb begin
		is_bit = (reg_kind == KIND_COIL) || (reg_kind == KIND_DISCRETE);
		if (reg_value[31]) begin
			reg_sat = 16'h0000;
		end else if (|reg_value[30:16]) begin
			reg_sat = REG_MAX;
		end else begin
			reg_sat = reg_value[15:0];
		end
		frame_in.data[0] = slave_q;
		frame_in.data[1] = FUNC_WRITE_SINGLE;
		frame_in.data[2] = reg_address[15:8];
		frame_in.data[3] = reg_address[7:0];
		if (is_bit) begin
			frame_in.data[4] = {7'd0, |reg_value};
			frame_in.data[5] = 8'h00;
		end else begin
			frame_in.data[4] = reg_sat[15:8];
			frame_in.data[5] = reg_sat[7:0];
		end
		frame_in.crc = CRC_INIT;
	end

	// pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= in_valid;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
			if (en_s3) begin
				valid_s3 <= valid_s2;
			end
			if (en_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	// pipeline payload: crc advances two bytes per stage
	always_ff @(posedge clk) begin
		if (en_s1) begin
			frame_s1 <= frame_in;
		end
		if (en_s2) begin
			frame_s2.data <= frame_s1.data;
			frame_s2.crc  <= crc_byte(crc_byte(frame_s1.crc, frame_s1.data[0]),
				frame_s1.data[1]);
		end
		if (en_s3) begin
			frame_s3.data <= frame_s2.data;
			frame_s3.crc  <= crc_byte(crc_byte(frame_s2.crc, frame_s2.data[2]),
				frame_s2.data[3]);
		end
		if (en_s4) begin
			frame_s4.data <= frame_s3.data;
			frame_s4.crc  <= crc_byte(crc_byte(frame_s3.crc, frame_s3.data[4]),
				frame_s3.data[5]);
		end
	end

	// output serializer
	mbwr_serializer u_ser (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (valid_s4),
		.load_frame (frame_s4),
		.load_ready (ser_ready),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.frame_byte (frame_byte),
		.byte_index (byte_index),
		.last_byte  (last_byte)
	);

endmodule

`default_nettype wire

/* dv/mbwr_frame_checker.sv */
// frame checker: predicts the eight request bytes per accepted word and compares the output
`timescale 1ns / 1ps

module mbwr_frame_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [7:0]         cfg_wdata,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [1:0]         reg_kind,
	input  logic [15:0]        reg_address,
	input  logic signed [31:0] reg_value,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [7:0]         frame_byte,
	input  logic [2:0]         byte_index,
	input  logic               last_byte,
	output int                 bytes_pending,
	output int                 mismatch_count
);
	import mbwr_pkg::*;

	typedef struct {
		byte_t     data;
		byte_pos_t pos;
		logic      last;
	} frame_word_t;

	frame_word_t frame_word_q[$];
	byte_t       slave_copy;

	initial begin
		bytes_pending  = 0;
		mismatch_count = 0;
		slave_copy     = SLAVE_RESET;
	end

	// bit-serial crc-16, lsb first, reflected polynomial
	function automatic logic [15:0] crc16_rtu_update(input logic [15:0] acc, input byte_t data);
		logic [15:0] r;
		logic        fb;
		r = acc;
		for (int n = 0; n < 8; n++) begin
			fb = r[0] ^ data[n];
			r  = {1'b0, r[15:1]};
			if (fb) begin
				r = r ^ CRC_POLY;
			end
		end
		return r;
	endfunction

	// build the function 06 request and queue its bytes in send order
	function automatic void queue_request_frame(input reg_kind_t kind, input logic [15:0] addr,
			input logic signed [31:0] value);
		byte_t       body [DataLen];
		logic [15:0] reg_word;
		logic [15:0] sum;
		frame_word_t w;
		body[0] = slave_copy;
		body[1] = FUNC_WRITE_SINGLE;
		body[2] = addr[15:8];
		body[3] = addr[7:0];
		case (kind)
			KIND_COIL, KIND_DISCRETE: begin
				// bit kinds: on/off flag then a zero byte
				body[4] = (value != 0) ? 8'h01 : 8'h00;
				body[5] = 8'h00;
			end
			default: begin
				// word kinds: clamp to the unsigned 16-bit range
				if (value < 0) begin
					reg_word = 16'h0000;
				end else if (value > 32'sd65535) begin
					reg_word = REG_MAX;
				end else begin
					reg_word = value[15:0];
				end
				body[4] = reg_word[15:8];
				body[5] = reg_word[7:0];
			end
		endcase
		sum = CRC_INIT;
		for (int i = 0; i < DataLen; i++) begin
			sum    = crc16_rtu_update(sum, body[i]);
			w.data = body[i];
			w.pos  = byte_pos_t'(i);
			w.last = 1'b0;
			frame_word_q.push_back(w);
		end
		w.data = sum[7:0];
		w.pos  = POS_CRC_L;
		w.last = 1'b0;
		frame_word_q.push_back(w);
		w.data = sum[15:8];
		w.pos  = POS_CRC_H;
		w.last = 1'b1;
		frame_word_q.push_back(w);
	endfunction

	// track config, predict on input words, compare output words
	always @(posedge clk) begin
		frame_word_t want;
		if (!arst_n) begin
			slave_copy = SLAVE_RESET;
			frame_word_q.delete();
		end else begin
			if (cfg_we) begin
				slave_copy = cfg_wdata;
			end
			if (in_valid && !in_stall) begin
				queue_request_frame(reg_kind_t'(reg_kind), reg_address, reg_value);
			end
			if (out_valid && !out_stall) begin
				if (frame_word_q.size() == 0) begin
					mismatch_count++;
					$display("%0t: unexpected word: expected none, actual byte %h index %0d last %b",
						$time, frame_byte, byte_index, last_byte);
				end else begin
					want = frame_word_q.pop_front();
					if (frame_byte !== want.data) begin
						mismatch_count++;
						$display("%0t: frame_byte mismatch at index %0d: expected %h, actual %h",
							$time, want.pos, want.data, frame_byte);
					end
					if (byte_index !== want.pos) begin
						mismatch_count++;
						$display("%0t: byte_index mismatch: expected %0d, actual %0d",
							$time, want.pos, byte_index);
					end
					if (last_byte !== want.last) begin
						mismatch_count++;
						$display("%0t: last_byte mismatch at index %0d: expected %b, actual %b",
							$time, want.pos, want.last, last_byte);
					end
				end
			end
		end
		bytes_pending = frame_word_q.size();
	end

endmodule

/* dv/modbus_write_register_frame_tb.sv */
// testbench top: clock, reset, request stimulus, output stall pattern and verdict
`timescale 1ns / 1ps

module modbus_write_register_frame_tb;
	import mbwr_pkg::*;

	localparam int CycleLimit = 200000;

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               cfg_we      = 1'b0;
	logic [7:0]         cfg_wdata   = 8'h00;
	logic               in_valid    = 1'b0;
	logic               in_stall;
	logic [1:0]         reg_kind    = 2'd0;
	logic [15:0]        reg_address = 16'h0000;
	logic signed [31:0] reg_value   = 32'sd0;
	logic               out_valid;
	logic               out_stall   = 1'b0;
	logic [7:0]         frame_byte;
	logic [2:0]         byte_index;
	logic               last_byte;

	int bytes_pending;
	int mismatch_count;
	int cycle_count = 0;
	int burst_left  = 1;

	modbus_write_register_frame uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.reg_kind    (reg_kind),
		.reg_address (reg_address),
		.reg_value   (reg_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.frame_byte  (frame_byte),
		.byte_index  (byte_index),
		.last_byte   (last_byte)
	);

	mbwr_frame_checker frame_chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.reg_kind       (reg_kind),
		.reg_address    (reg_address),
		.reg_value      (reg_value),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.frame_byte     (frame_byte),
		.byte_index     (byte_index),
		.last_byte      (last_byte),
		.bytes_pending  (bytes_pending),
		.mismatch_count (mismatch_count)
	);

	// 12 ns clock
	initial begin
		forever begin
			#6 clk = ~clk;
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CycleLimit) begin
			$display("Verification failed");
			$finish;
		end
	end

	// output stall pattern: modes switch after random spans
	always @(negedge clk) begin
		static int stall_mode = 0;
		static int stall_span = 0;
		static int hold_left  = 0;
		if (stall_span == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_span = $urandom_range(16, 160);
		end else begin
			stall_span--;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 7) == 0);
			2: out_stall <= 1'($urandom_range(0, 1));
			default: begin
				// long holds now and then
				if (hold_left > 0) begin
					hold_left--;
					out_stall <= 1'b1;
				end else if ($urandom_range(0, 15) == 0) begin
					hold_left = $urandom_range(3, 20);
					out_stall <= 1'b1;
				end else begin
					out_stall <= 1'b0;
				end
			end
		endcase
	end

	// offer one request word, hold it until taken, then burst or gap
	task automatic send_request(input reg_kind_t kind, input logic [15:0] addr,
			input logic signed [31:0] value);
		int gap;
		in_valid    <= 1'b1;
		reg_kind    <= kind;
		reg_address <= addr;
		reg_value   <= value;
		do begin
			@(posedge clk);
		end while (in_stall);
		@(negedge clk);
		burst_left--;
		if (burst_left <= 0) begin
			gap = $urandom_range(0, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
	endtask

	// stop offering and let every expected byte come out
	task automatic drain_requests();
		in_valid <= 1'b0;
		while (bytes_pending != 0) begin
			@(negedge clk);
		end
		repeat (10) @(negedge clk);
	endtask

	// slave address write while idle
	task automatic set_slave_address(input logic [7:0] addr);
		cfg_we    <= 1'b1;
		cfg_wdata <= addr;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// random requests with values weighted toward the clamp edges
	task automatic send_random_requests(input int count);
		logic signed [31:0] value;
		for (int n = 0; n < count; n++) begin
			case ($urandom_range(0, 9))
				0:       value = 32'sd0;
				1, 2:    value = $urandom_range(0, 65535);
				3:       value = 32'sd65530 + $urandom_range(0, 10);
				4:       value = -$signed({1'b0, 31'($urandom_range(1, 5))});
				5:       value = $urandom | 32'h8000_0000;
				6:       value = $urandom & 32'h7FFF_FFFF;
				7:       value = 32'sd1 <<< $urandom_range(0, 31);
				default: value = $urandom;
			endcase
			send_request(reg_kind_t'($urandom_range(0, 3)), 16'($urandom), value);
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (3) @(negedge clk);

		// directed: reset slave address, field extremes and clamp cases
		send_request(KIND_COIL, 16'h0000, 32'sd0);
		send_request(KIND_COIL, 16'hFFFF, 32'sd1);
		send_request(KIND_COIL, 16'h1234, -32'sd1);
		send_request(KIND_COIL, 16'h00FF, 32'sh8000_0000);
		send_request(KIND_COIL, 16'hFF00, 32'sh0001_0000);
		send_request(KIND_DISCRETE, 16'h0001, 32'sd0);
		send_request(KIND_DISCRETE, 16'h8000, 32'sh7FFF_FFFF);
		send_request(KIND_HOLDING, 16'h0000, 32'sd0);
		send_request(KIND_HOLDING, 16'hFFFF, 32'sd65535);
		send_request(KIND_HOLDING, 16'h0102, 32'sd65536);
		send_request(KIND_HOLDING, 16'hA5A5, -32'sd1);
		send_request(KIND_HOLDING, 16'h5A5A, 32'sh8000_0000);
		send_request(KIND_HOLDING, 16'h7FFF, 32'sh7FFF_FFFF);
		send_request(KIND_INPUT, 16'h0010, 32'sd12345);
		send_request(KIND_INPUT, 16'h0020, -32'sd5);
		send_request(KIND_INPUT, 16'h0030, 32'sd70000);
		send_request(KIND_INPUT, 16'hFFFE, 32'sd1);
		drain_requests();

		// random phases over several slave addresses
		set_slave_address(8'h00);
		send_random_requests(60);
		drain_requests();
		set_slave_address(8'hFF);
		send_random_requests(60);
		drain_requests();
		for (int p = 0; p < 3; p++) begin
			set_slave_address(8'($urandom_range(1, 254)));
			send_random_requests(57);
			drain_requests();
		end

		if (mismatch_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
